/* rtl/gcfb_pkg.sv */
package gcfb_pkg;

    typedef enum logic [1:0] {
        OP_ZOOM   = 2'd0,
        OP_SPEED  = 2'd1,
        OP_ANGLE  = 2'd2,
        OP_CENTER = 2'd3
    } op_t;

    localparam logic [7:0]  SYNC_0      = 8'h55;
    localparam logic [7:0]  SYNC_1      = 8'h66;
    localparam logic [7:0]  CTRL_BYTE   = 8'h01;
    localparam logic [7:0]  ZERO_BYTE   = 8'h00;
    localparam logic [7:0]  CENTER_ARG  = 8'h01;
    localparam logic [7:0]  ID_ZOOM     = 8'h0f;
    localparam logic [7:0]  ID_SPEED    = 8'h07;
    localparam logic [7:0]  ID_ANGLE    = 8'h0e;
    localparam logic [7:0]  ID_CENTER   = 8'h08;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // byte positions inside the frame header
    localparam logic [3:0] POS_SYNC_0  = 4'd0;
    localparam logic [3:0] POS_SYNC_1  = 4'd1;
    localparam logic [3:0] POS_CTRL    = 4'd2;
    localparam logic [3:0] POS_LEN_LO  = 4'd3;
    localparam logic [3:0] POS_LEN_HI  = 4'd4;
    localparam logic [3:0] POS_SEQ_LO  = 4'd5;
    localparam logic [3:0] POS_SEQ_HI  = 4'd6;
    localparam logic [3:0] POS_CMD     = 4'd7;
    localparam logic [3:0] POS_PAYLOAD = 4'd8;

    typedef struct packed {
        logic [7:0]       cmd_id;
        logic [2:0]       plen;
        logic [3:0][7:0]  payload;
    } cmd_desc_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/gcfb_front.sv */
module gcfb_front (
    input  logic [1:0]             operation,
    input  logic [15:0]            first_value,
    input  logic [15:0]            second_value,
    output gcfb_pkg::cmd_desc_t    desc
);

    always_comb
    begin
        desc = '0;
        unique case (gcfb_pkg::op_t'(operation))
            gcfb_pkg::OP_ZOOM:
            begin
                desc.cmd_id     = gcfb_pkg::ID_ZOOM;
                desc.plen       = 3'd2;
                desc.payload[0] = first_value[7:0];
                desc.payload[1] = second_value[7:0];
            end
            gcfb_pkg::OP_SPEED:
            begin
                desc.cmd_id     = gcfb_pkg::ID_SPEED;
                desc.plen       = 3'd2;
                desc.payload[0] = first_value[7:0];
                desc.payload[1] = second_value[7:0];
            end
            gcfb_pkg::OP_ANGLE:
            begin
                desc.cmd_id     = gcfb_pkg::ID_ANGLE;
                desc.plen       = 3'd4;
                desc.payload[0] = first_value[7:0];
                desc.payload[1] = first_value[15:8];
                desc.payload[2] = second_value[7:0];
                desc.payload[3] = second_value[15:8];
            end
            default:
            begin
                desc.cmd_id     = gcfb_pkg::ID_CENTER;
                desc.plen       = 3'd1;
                desc.payload[0] = gcfb_pkg::CENTER_ARG;
            end
        endcase
    end

endmodule

/* rtl/gcfb_queue.sv */
module gcfb_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  gcfb_pkg::cmd_desc_t    wr_data,
    output logic                   full,
    input  logic                   rd_en,
    output gcfb_pkg::cmd_desc_t    rd_data,
    output logic                   rd_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gcfb_pkg::cmd_desc_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/gcfb_back.sv */
module gcfb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gcfb_pkg::cmd_desc_t    desc,
    input  logic                   desc_valid,
    output logic                   desc_done,
    output logic [7:0]             frame_byte,
    output logic                   last_byte,
    output logic                   empty,
    input  logic                   pop
);

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]  cur_byte;
    logic [3:0]  crc_lo_pos;
    logic        is_last;
    logic        is_data;
    logic        advance;

    assign crc_lo_pos = gcfb_pkg::POS_PAYLOAD + {1'b0, desc.plen};
    assign is_data    = (idx_reg < crc_lo_pos);
    assign is_last    = (idx_reg == crc_lo_pos + 4'd1);
    // refill the output register in the same cycle it is drained
    assign advance    = desc_valid && (!out_valid_reg || pop);
    assign desc_done  = advance && is_last;

    always_comb
    begin
        case (idx_reg)
            gcfb_pkg::POS_SYNC_0: cur_byte = gcfb_pkg::SYNC_0;
            gcfb_pkg::POS_SYNC_1: cur_byte = gcfb_pkg::SYNC_1;
            gcfb_pkg::POS_CTRL:   cur_byte = gcfb_pkg::CTRL_BYTE;
            gcfb_pkg::POS_LEN_LO: cur_byte = {5'd0, desc.plen};
            gcfb_pkg::POS_LEN_HI: cur_byte = gcfb_pkg::ZERO_BYTE;
            gcfb_pkg::POS_SEQ_LO: cur_byte = gcfb_pkg::ZERO_BYTE;
            gcfb_pkg::POS_SEQ_HI: cur_byte = gcfb_pkg::ZERO_BYTE;
            gcfb_pkg::POS_CMD:    cur_byte = desc.cmd_id;
            default:
            begin
                if (is_data)
                begin
                    cur_byte = desc.payload[idx_reg[1:0]];
                end
                else if (idx_reg == crc_lo_pos)
                begin
                    cur_byte = crc_reg[7:0];
                end
                else
                begin
                    cur_byte = crc_reg[15:8];
                end
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = is_last;
            if (is_last)
            begin
                idx_next = '0;
                crc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
                if (is_data)
                begin
                    crc_next = gcfb_pkg::crc_update(crc_reg, cur_byte);
                end
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign frame_byte = out_byte_reg;
    assign last_byte  = out_last_reg;
    assign empty      = !out_valid_reg;

endmodule

/* rtl/gimbal_command_frame_builder_core.sv */
// channel   direction  handshake             payload
// command   in         push / full           operation, first_value, second_value
// frame     out        empty / pop           frame_byte, last_byte
//
// one frame byte per cycle unless pop stalls the serializer: 12 bytes for zoom
// and speed, 14 for angle, 11 for centering; frames follow each other with no gap
// commands wait in a QUEUE_DEPTH entry queue between decode and serializer
// the crc takes one byte per unstalled cycle as header and payload bytes go out
// reset (rst_n low, asynchronous) empties the queue and the output register
// a stalled pop holds the current byte and, once the queue fills, raises full
module gimbal_command_frame_builder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    gcfb_pkg::cmd_desc_t in_desc;
    gcfb_pkg::cmd_desc_t head_desc;
    logic                head_valid;
    logic                head_done;

    gcfb_front u_front (
        .operation    (operation),
        .first_value  (first_value),
        .second_value (second_value),
        .desc         (in_desc)
    );

    gcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (in_desc),
        .full     (full),
        .rd_en    (head_done),
        .rd_data  (head_desc),
        .rd_valid (head_valid)
    );

    gcfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (head_desc),
        .desc_valid (head_valid),
        .desc_done  (head_done),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

/* tb/gcfb_frame_checker.sv */
`timescale 1ns / 1ps

module gcfb_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  operation,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output int          mismatch_count,
    output int          bytes_outstanding,
    output int          frames_checked,
    output int          bytes_checked
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    frame_beat_t expected_beats [$];

    // appends the full byte sequence of one command frame, crc included
    task automatic build_frame(input gcfb_pkg::op_t op, input logic [15:0] v1,
                               input logic [15:0] v2);
        logic [7:0]  body [$];
        logic [7:0]  cmd_id;
        logic [15:0] plen;
        logic [15:0] crc;
        logic        feedback;
        frame_beat_t beat;
        case (op)
            gcfb_pkg::OP_ZOOM:
            begin
                cmd_id = gcfb_pkg::ID_ZOOM;
                plen   = 16'd2;
            end
            gcfb_pkg::OP_SPEED:
            begin
                cmd_id = gcfb_pkg::ID_SPEED;
                plen   = 16'd2;
            end
            gcfb_pkg::OP_ANGLE:
            begin
                cmd_id = gcfb_pkg::ID_ANGLE;
                plen   = 16'd4;
            end
            default:
            begin
                cmd_id = gcfb_pkg::ID_CENTER;
                plen   = 16'd1;
            end
        endcase
        body.push_back(gcfb_pkg::SYNC_0);
        body.push_back(gcfb_pkg::SYNC_1);
        body.push_back(gcfb_pkg::CTRL_BYTE);
        body.push_back(plen[7:0]);
        body.push_back(plen[15:8]);
        body.push_back(gcfb_pkg::ZERO_BYTE);
        body.push_back(gcfb_pkg::ZERO_BYTE);
        body.push_back(cmd_id);
        case (op)
            gcfb_pkg::OP_ANGLE:
            begin
                body.push_back(v1[7:0]);
                body.push_back(v1[15:8]);
                body.push_back(v2[7:0]);
                body.push_back(v2[15:8]);
            end
            gcfb_pkg::OP_CENTER:
            begin
                body.push_back(gcfb_pkg::CENTER_ARG);
            end
            default:
            begin
                // only the low byte of each value goes out
                body.push_back(v1[7:0]);
                body.push_back(v2[7:0]);
            end
        endcase
        // crc-16/xmodem, shifted one data bit at a time, msb first
        crc = 16'h0000;
        foreach (body[i])
        begin
            for (int k = 7; k >= 0; k--)
            begin
                feedback = crc[15] ^ body[i][k];
                crc = {crc[14:0], 1'b0};
                if (feedback)
                begin
                    crc = crc ^ gcfb_pkg::CRC_POLY;
                end
            end
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        foreach (body[i])
        begin
            beat.value = body[i];
            beat.last  = (i == body.size() - 1);
            expected_beats.push_back(beat);
        end
    endtask

    initial
    begin
        mismatch_count    = 0;
        bytes_outstanding = 0;
        frames_checked    = 0;
        bytes_checked     = 0;
    end

    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected frame byte %02h (last_byte %0b) with nothing pending",
                           frame_byte, last_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    bytes_checked++;
                    if (frame_byte !== want.value)
                    begin
                        $error("frame_byte: expected %02h, actual %02h", want.value, frame_byte);
                        mismatch_count++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte: expected %0b, actual %0b", want.last, last_byte);
                        mismatch_count++;
                    end
                    if (want.last)
                    begin
                        frames_checked++;
                    end
                end
            end
            if (push && !full)
            begin
                build_frame(gcfb_pkg::op_t'(operation), first_value, second_value);
            end
            bytes_outstanding = expected_beats.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_COMMANDS = 356;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  operation;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic        empty;
    logic        pop;
    logic [7:0]  frame_byte;
    logic        last_byte;

    int mismatch_count;
    int bytes_outstanding;
    int frames_checked;
    int bytes_checked;
    int cycle_count = 0;
    int commands_sent = 0;
    int op_count [4] = '{0, 0, 0, 0};

    always #2 clk = ~clk;

    gimbal_command_frame_builder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .first_value  (first_value),
        .second_value (second_value),
        .empty        (empty),
        .pop          (pop),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte)
    );

    gcfb_frame_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .operation         (operation),
        .first_value       (first_value),
        .second_value      (second_value),
        .empty             (empty),
        .pop               (pop),
        .frame_byte        (frame_byte),
        .last_byte         (last_byte),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding),
        .frames_checked    (frames_checked),
        .bytes_checked     (bytes_checked)
    );

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_command(input gcfb_pkg::op_t op, input logic [15:0] v1,
                                input logic [15:0] v2);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if ((commands_sent / 40) % 3 == 0)
        begin
            gap = 0;
        end
        else if (r < 55)
        begin
            gap = 0;
        end
        else if (r < 90)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            gap = $urandom_range(4, 10);
        end
        else
        begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        operation    <= op;
        first_value  <= v1;
        second_value <= v2;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        commands_sent++;
        op_count[op]++;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: mostly short stalls, some long ones, calm stretches and one long hold-off
    initial
    begin
        int  stall_left;
        int  r;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        pop        = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && commands_sent >= 60)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if ((cycle_count / 200) % 4 == 1)
            begin
                pop <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    pop <= 1'b1;
                end
                else
                begin
                    pop <= 1'b0;
                    stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    initial
    begin
        logic [15:0] dir_first  [6];
        logic [15:0] dir_second [6];
        logic [15:0] v1;
        logic [15:0] v2;
        logic [15:0] corner [4];
        dir_first  = '{16'h0000, 16'hffff, 16'h00ff, 16'hff00, 16'haaaa, 16'h8001};
        dir_second = '{16'h0000, 16'hffff, 16'hff00, 16'h00ff, 16'h5555, 16'h7ffe};
        corner     = '{16'h0000, 16'hffff, 16'h00ff, 16'hff00};
        rst_n        = 1'b0;
        push         = 1'b0;
        operation    = gcfb_pkg::OP_ZOOM;
        first_value  = 16'h0000;
        second_value = 16'h0000;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every command with extreme and patterned values, high bytes ignored for zoom and speed
        for (int o = 0; o < 4; o++)
        begin
            for (int j = 0; j < 6; j++)
            begin
                send_command(gcfb_pkg::op_t'(o), dir_first[j], dir_second[j]);
            end
        end

        repeat (RANDOM_COMMANDS)
        begin
            v1 = $urandom_range(0, 9) == 0 ? corner[$urandom_range(0, 3)] : 16'($urandom);
            v2 = $urandom_range(0, 9) == 0 ? corner[$urandom_range(0, 3)] : 16'($urandom);
            send_command(gcfb_pkg::op_t'($urandom_range(0, 3)), v1, v2);
        end
        push <= 1'b0;

        wait (bytes_outstanding == 0);
        repeat (40) @(posedge clk);
        $display("sent %0d commands: %0d zoom, %0d speed, %0d angle, %0d centering",
                 commands_sent, op_count[gcfb_pkg::OP_ZOOM], op_count[gcfb_pkg::OP_SPEED],
                 op_count[gcfb_pkg::OP_ANGLE], op_count[gcfb_pkg::OP_CENTER]);
        $display("compared %0d frames, %0d bytes, with random stalls and a long output hold-off",
                 frames_checked, bytes_checked);
        if (mismatch_count == 0 && bytes_outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
